// ===== rtl/mecanum_inverse_kinematics_macros.svh =====
// Assertion macros for the mecanum inverse kinematics block.
// Depends on nothing; included by the files that assert.
`ifndef MECANUM_INVERSE_KINEMATICS_MACROS_SVH
`define MECANUM_INVERSE_KINEMATICS_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MIK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define MIK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mik_pkg.sv =====
// Shared constants for the mecanum inverse kinematics block.
// Used by mik_cordic and mecanum_inverse_kinematics; depends on nothing.
package mik_pkg;

   localparam int DataBitsDef  = 24;
   localparam int FracBitsDef  = 12;
   localparam int AngleBitsDef = 16;

   localparam int RadiusBits    = 12;
   localparam int InvRadiusBits = 20;
   localparam int CsrIndexBits  = 1;
   localparam int CsrDataBits   = InvRadiusBits;

   localparam logic [CsrIndexBits-1:0] CsrWheelRadius    = 1'd0;
   localparam logic [CsrIndexBits-1:0] CsrInvWheelRadius = 1'd1;

   localparam logic [RadiusBits-1:0]    RadiusReset    = 12'd311;
   localparam logic [InvRadiusBits-1:0] InvRadiusReset = 20'd53898;

   localparam int WheelCount = 4;
   localparam int LaneCount  = 2 * WheelCount;

   localparam int CordicBits  = 32;
   localparam int CordicSteps = 20;
   localparam int QShift      = 30;

   localparam logic [1:0] Quad0 = 2'd0;
   localparam logic [1:0] Quad1 = 2'd1;
   localparam logic [1:0] Quad2 = 2'd2;
   localparam logic [1:0] Quad3 = 2'd3;

   localparam logic signed [CordicBits-1:0] CordicGain   = 32'sd652032875;
   localparam logic signed [CordicBits-1:0] Sqrt2Q30     = 32'sd1518500250;
   localparam logic signed [CordicBits-1:0] HalfSqrt2Q30 = 32'sd759250125;

   // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
   localparam logic signed [CordicBits-1:0] CordicAtan [CordicSteps] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458908, 32'sd85004757, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335086,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304
   };

endpackage

// ===== rtl/mecanum_inverse_kinematics.sv =====
// Mecanum inverse kinematics: yaw rotation, wheel mixing, radius scaling.
// Top level; depends on mik_pkg, mik_cordic and the assertion macros header.
// Takes one chassis command per clock while req_tready is high and returns
// one beat of four wheel speeds and four wheel torques for each, in order.
// Each goes through the 22-stage CORDIC that makes the yaw cosine and sine,
// then the product, rounding, mixing, scaling and saturation stages and the
// output register. A two-entry output buffer lets the pipeline keep taking
// commands while a result waits; req_tready drops only once that buffer is full.
module mecanum_inverse_kinematics import mik_pkg::*; #(
   parameter int DATA_BITS  = DataBitsDef,
   parameter int FRAC_BITS  = FracBitsDef,
   parameter int ANGLE_BITS = AngleBitsDef,
   localparam int ReqBits     = 6 * DATA_BITS + ANGLE_BITS,
   localparam int ReqDataBits = ((ReqBits + 7) / 8) * 8,
   localparam int RspBits     = LaneCount * DATA_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // vx_ref, vy_ref, vz_ref, fx_ref, fy_ref, fz_ref, yaw_angle, zero fill
   input  logic [ReqDataBits-1:0]   req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // wheel1..4_speed, wheel1..4_torque
   output logic [RspBits-1:0]       rsp_tdata,
   input  logic                     csr_we,
   input  logic [CsrIndexBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0]   csr_wdata
);

`include "mecanum_inverse_kinematics_macros.svh"

   localparam int PayBits   = 6 * DATA_BITS;
   localparam int ProdBits  = DATA_BITS + CordicBits;
   localparam int RotBits   = DATA_BITS + 2;
   localparam int MixBits   = DATA_BITS + 4;
   localparam int ScaleBits = MixBits + InvRadiusBits + 1;
   localparam int HiBits    = ScaleBits - DATA_BITS + 1;

   localparam logic signed [ProdBits:0] RotHalf =
      {{(ProdBits - QShift + 1){1'b0}}, 1'b1, {(QShift - 1){1'b0}}};
   localparam logic signed [ScaleBits-1:0] SpdHalf =
      {{(ScaleBits - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [ScaleBits-1:0] TrqHalf =
      {{(ScaleBits - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 1){1'b0}}};

   logic en;

   // configuration registers
   logic [RadiusBits-1:0]    rad_ff, rad_in;
   logic [InvRadiusBits-1:0] inv_ff, inv_in;

   always_comb begin
      rad_in = rad_ff;
      inv_in = inv_ff;
      if (csr_we) begin
         case (csr_index)
            CsrWheelRadius:    rad_in = csr_wdata[RadiusBits-1:0];
            CsrInvWheelRadius: inv_in = csr_wdata[InvRadiusBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff <= RadiusReset;
         inv_ff <= InvRadiusReset;
      end else begin
         rad_ff <= rad_in;
         inv_ff <= inv_in;
      end
   end

   // cosine and sine of the yaw, command fields carried alongside
   logic                         cs_valid;
   logic signed [CordicBits-1:0] cs_cos, cs_sin;
   logic [PayBits-1:0]           cs_pay;

   mik_cordic #(
      .ANGLE_BITS (ANGLE_BITS),
      .PAY_BITS   (PayBits)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .angle     (req_tdata[PayBits +: ANGLE_BITS]),
      .pay_in    (req_tdata[PayBits-1:0]),
      .out_valid (cs_valid),
      .cos_out   (cs_cos),
      .sin_out   (cs_sin),
      .pay_out   (cs_pay)
   );

   // stage 1: rotation and k*z products
   logic signed [DATA_BITS-1:0] vx, vy, vz, fx, fy, fz;
   logic                        p1_valid_ff;
   logic signed [ProdBits-1:0]  prod_ff [LaneCount];
   logic signed [ProdBits-1:0]  prod_in [LaneCount];
   logic signed [ProdBits-1:0]  kzp_ff  [2];
   logic signed [ProdBits-1:0]  kzp_in  [2];

   assign vx = cs_pay[0*DATA_BITS +: DATA_BITS];
   assign vy = cs_pay[1*DATA_BITS +: DATA_BITS];
   assign vz = cs_pay[2*DATA_BITS +: DATA_BITS];
   assign fx = cs_pay[3*DATA_BITS +: DATA_BITS];
   assign fy = cs_pay[4*DATA_BITS +: DATA_BITS];
   assign fz = cs_pay[5*DATA_BITS +: DATA_BITS];

   always_comb begin
      prod_in[0] = vx * cs_cos;
      prod_in[1] = vy * cs_sin;
      prod_in[2] = vx * cs_sin;
      prod_in[3] = vy * cs_cos;
      prod_in[4] = fx * cs_cos;
      prod_in[5] = fy * cs_sin;
      prod_in[6] = fx * cs_sin;
      prod_in[7] = fy * cs_cos;
      kzp_in[0]  = vz * Sqrt2Q30;
      kzp_in[1]  = fz * HalfSqrt2Q30;
   end

   // stage 2: round rotated pairs and k*z terms
   logic                      p2_valid_ff;
   logic signed [RotBits-1:0] rot_ff [4];
   logic signed [RotBits-1:0] rot_in [4];
   logic signed [RotBits-1:0] kz_ff  [2];
   logic signed [RotBits-1:0] kz_in  [2];

   always_comb begin
      logic signed [ProdBits:0] rsum_x, rsum_y, ksum;
      logic signed [ProdBits:0] rsh_x, rsh_y, ksh;
      for (int k = 0; k < 2; k++) begin
         rsum_x = prod_ff[4*k] - prod_ff[4*k+1] + RotHalf;
         rsum_y = prod_ff[4*k+2] + prod_ff[4*k+3] + RotHalf;
         ksum   = kzp_ff[k] + RotHalf;
         rsh_x  = rsum_x >>> QShift;
         rsh_y  = rsum_y >>> QShift;
         ksh    = ksum >>> QShift;
         rot_in[2*k]   = rsh_x[RotBits-1:0];
         rot_in[2*k+1] = rsh_y[RotBits-1:0];
         kz_in[k]      = ksh[RotBits-1:0];
      end
   end

   // stage 3: wheel mix
   logic                      p3_valid_ff;
   logic signed [MixBits-1:0] w_ff [LaneCount];
   logic signed [MixBits-1:0] w_in [LaneCount];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         w_in[4*k]   = -rot_ff[2*k] + rot_ff[2*k+1] + kz_ff[k];
         w_in[4*k+1] = -rot_ff[2*k] - rot_ff[2*k+1] + kz_ff[k];
         w_in[4*k+2] =  rot_ff[2*k] - rot_ff[2*k+1] + kz_ff[k];
         w_in[4*k+3] =  rot_ff[2*k] + rot_ff[2*k+1] + kz_ff[k];
      end
   end

   // stage 4: radius scaling
   logic                          p4_valid_ff;
   logic signed [InvRadiusBits:0] spd_fac, trq_fac;
   logic signed [ScaleBits-1:0]   scl_ff [LaneCount];
   logic signed [ScaleBits-1:0]   scl_in [LaneCount];

   assign spd_fac = $signed({1'b0, inv_ff});
   assign trq_fac = $signed({{(InvRadiusBits - RadiusBits + 1){1'b0}}, rad_ff});

   always_comb begin
      for (int j = 0; j < LaneCount; j++) begin
         scl_in[j] = w_ff[j] * ((j < WheelCount) ? spd_fac : trq_fac);
      end
   end

   // stage 5: round and saturate
   logic               done_valid_ff;
   logic [RspBits-1:0] done_ff, done_in;

   always_comb begin
      logic signed [ScaleBits-1:0] rnd, rsh;
      logic [HiBits-1:0]           hi_bits;
      for (int j = 0; j < LaneCount; j++) begin
         if (j < WheelCount) begin
            rnd = scl_ff[j] + SpdHalf;
            rsh = rnd >>> FRAC_BITS;
         end else begin
            rnd = scl_ff[j] + TrqHalf;
            rsh = rnd >>> (FRAC_BITS + 2);
         end
         hi_bits = rsh[ScaleBits-1:DATA_BITS-1];
         if ((|hi_bits) && !(&hi_bits)) begin
            done_in[j*DATA_BITS +: DATA_BITS] = rsh[ScaleBits-1] ?
               {1'b1, {(DATA_BITS - 1){1'b0}}} : {1'b0, {(DATA_BITS - 1){1'b1}}};
         end else begin
            done_in[j*DATA_BITS +: DATA_BITS] = rsh[DATA_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         p3_valid_ff   <= 1'b0;
         p4_valid_ff   <= 1'b0;
         done_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff   <= cs_valid;
         p2_valid_ff   <= p1_valid_ff;
         p3_valid_ff   <= p2_valid_ff;
         p4_valid_ff   <= p3_valid_ff;
         done_valid_ff <= p4_valid_ff;
      end
      if (en) begin
         prod_ff <= prod_in;
         kzp_ff  <= kzp_in;
         rot_ff  <= rot_in;
         kz_ff   <= kz_in;
         w_ff    <= w_in;
         scl_ff  <= scl_in;
         done_ff <= done_in;
      end
   end

   // output register with skid entry
   logic               out_valid_ff, out_valid_in;
   logic [RspBits-1:0] out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [RspBits-1:0] skid_data_ff, skid_data_in;
   logic               take;

   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = done_valid_ff;
         out_data_in  = done_ff;
      end else if (done_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `MIK_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_tvalid, "skid full, output empty")
   `MIK_ASSERT_NEXT(a_skid_fill, clock, reset, done_valid_ff && req_tready && rsp_tvalid && !rsp_tready, skid_valid_ff, "stalled beat not parked")
   `MIK_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && rsp_tready, !skid_valid_ff && rsp_tvalid, "skid beat not moved to output")

endmodule

// ===== rtl/mik_cordic.sv =====
// Pipelined rotation-mode CORDIC: binary angle in, Q30 cosine and sine out.
// One step per stage, side data carried alongside. Depends on mik_pkg.
module mik_cordic import mik_pkg::*; #(
   parameter int ANGLE_BITS = AngleBitsDef,
   parameter int PAY_BITS   = 6 * DataBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [ANGLE_BITS-1:0]        angle,
   input  logic [PAY_BITS-1:0]          pay_in,
   output logic                         out_valid,
   output logic signed [CordicBits-1:0] cos_out,
   output logic signed [CordicBits-1:0] sin_out,
   output logic [PAY_BITS-1:0]          pay_out
);

   localparam int PadBits = CordicBits - ANGLE_BITS;

   logic [CordicBits-1:0]        turn_in;
   logic [CordicSteps:0]         valid_ff;
   logic signed [CordicBits-1:0] x_ff   [CordicSteps+1];
   logic signed [CordicBits-1:0] y_ff   [CordicSteps+1];
   logic signed [CordicBits-1:0] z_ff   [CordicSteps+1];
   logic [1:0]                   quad_ff[CordicSteps+1];
   logic [PAY_BITS-1:0]          pay_ff [CordicSteps+1];

   logic                         out_valid_ff;
   logic signed [CordicBits-1:0] cos_ff, cos_in;
   logic signed [CordicBits-1:0] sin_ff, sin_in;
   logic [PAY_BITS-1:0]          pay_out_ff;

   assign turn_in = {angle, {PadBits{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= CordicGain;
         y_ff[0]    <= '0;
         z_ff[0]    <= {2'b00, turn_in[CordicBits-3:0]};
         quad_ff[0] <= turn_in[CordicBits-1 -: 2];
         pay_ff[0]  <= pay_in;
      end
   end

   for (genvar gi = 0; gi < CordicSteps; gi++) begin : g_step
      logic signed [CordicBits-1:0] dx, dy, x_in, y_in, z_in;

      assign dx = y_ff[gi] >>> gi;
      assign dy = x_ff[gi] >>> gi;

      always_comb begin
         if (!z_ff[gi][CordicBits-1]) begin
            x_in = x_ff[gi] - dx;
            y_in = y_ff[gi] + dy;
            z_in = z_ff[gi] - CordicAtan[gi];
         end else begin
            x_in = x_ff[gi] + dx;
            y_in = y_ff[gi] - dy;
            z_in = z_ff[gi] + CordicAtan[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[gi+1] <= 1'b0;
         end else if (en) begin
            valid_ff[gi+1] <= valid_ff[gi];
         end
         if (en) begin
            x_ff[gi+1]    <= x_in;
            y_ff[gi+1]    <= y_in;
            z_ff[gi+1]    <= z_in;
            quad_ff[gi+1] <= quad_ff[gi];
            pay_ff[gi+1]  <= pay_ff[gi];
         end
      end
   end

   // fold the first-quadrant result out to the full turn
   always_comb begin
      case (quad_ff[CordicSteps])
         Quad0: begin
            cos_in = x_ff[CordicSteps];
            sin_in = y_ff[CordicSteps];
         end
         Quad1: begin
            cos_in = -y_ff[CordicSteps];
            sin_in = x_ff[CordicSteps];
         end
         Quad2: begin
            cos_in = -x_ff[CordicSteps];
            sin_in = -y_ff[CordicSteps];
         end
         Quad3: begin
            cos_in = y_ff[CordicSteps];
            sin_in = -x_ff[CordicSteps];
         end
         default: begin
            cos_in = x_ff[CordicSteps];
            sin_in = y_ff[CordicSteps];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[CordicSteps];
      end
      if (en) begin
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         pay_out_ff <= pay_ff[CordicSteps];
      end
   end

   assign out_valid = out_valid_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign pay_out   = pay_out_ff;

endmodule
